// File: hw/rtl/tcm_pkg.sv
package tcm_pkg;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic direct_rgb;
    logic wide_palette;
  } cfg_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_RGB   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_PALETTE = 1'b1;

  localparam logic [7:0] BASIC_LIMIT = 8'd16;
  localparam logic [7:0] CUBE_BASE   = 8'd16;
  localparam logic [7:0] GRAY_BASE   = 8'd232;

  function automatic rgb_t basic_rgb(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = {8'd0,   8'd0,   8'd0};
      4'd1:    c = {8'd205, 8'd0,   8'd0};
      4'd2:    c = {8'd0,   8'd205, 8'd0};
      4'd3:    c = {8'd205, 8'd205, 8'd0};
      4'd4:    c = {8'd0,   8'd0,   8'd238};
      4'd5:    c = {8'd205, 8'd0,   8'd205};
      4'd6:    c = {8'd0,   8'd205, 8'd205};
      4'd7:    c = {8'd229, 8'd229, 8'd229};
      4'd8:    c = {8'd127, 8'd127, 8'd127};
      4'd9:    c = {8'd255, 8'd0,   8'd0};
      4'd10:   c = {8'd0,   8'd255, 8'd0};
      4'd11:   c = {8'd255, 8'd255, 8'd0};
      4'd12:   c = {8'd92,  8'd92,  8'd255};
      4'd13:   c = {8'd255, 8'd0,   8'd255};
      4'd14:   c = {8'd0,   8'd255, 8'd255};
      default: c = {8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] v);
    logic [7:0] lvl;
    case (v)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd95;
      3'd2:    lvl = 8'd135;
      3'd3:    lvl = 8'd175;
      3'd4:    lvl = 8'd215;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  function automatic logic [2:0] cube_step(input logic [7:0] v);
    logic [2:0] s;
    s = 3'(v >= 8'd75) + 3'(v >= 8'd115) + 3'(v >= 8'd155)
      + 3'(v >= 8'd195) + 3'(v >= 8'd235);
    return s;
  endfunction

endpackage

// File: hw/rtl/tcm_quantize.sv
module tcm_quantize (
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] index
);
  import tcm_pkg::*;

  logic [7:0]  gray_ofs;
  logic [15:0] gray_prod;
  logic [4:0]  gray_step;
  logic [8:0]  gray_sum;
  logic [7:0]  gray_idx;
  logic [7:0]  cube_idx;

  // Division of the gray offset by ten is a reciprocal multiply; exact for 0..240.
  assign gray_ofs  = red - 8'd8;
  assign gray_prod = 16'(gray_ofs * 8'd205);
  assign gray_step = gray_prod[15:11];
  assign gray_sum  = {1'b0, GRAY_BASE} + {4'd0, gray_step};
  assign gray_idx  = gray_sum[8] ? 8'd255 : gray_sum[7:0];

  assign cube_idx = CUBE_BASE + 8'(cube_step(red) * 6'd36) + 8'(cube_step(green) * 4'd6)
                  + {5'd0, cube_step(blue)};

  always_comb begin
    if (red == green && green == blue) begin
      if (red < 8'd8) begin
        index = 8'd16;
      end else if (red > 8'd248) begin
        index = 8'd231;
      end else begin
        index = gray_idx;
      end
    end else begin
      index = cube_idx;
    end
  end

endmodule

// File: hw/rtl/tcm_expand.sv
module tcm_expand (
  input  logic [7:0]    index,
  output tcm_pkg::rgb_t rgb
);
  import tcm_pkg::*;

  logic [7:0]  n;
  logic [17:0] p6;
  logic [5:0]  q6;
  logic [13:0] p36;
  logic [2:0]  d_r;
  logic [2:0]  d_g;
  logic [2:0]  d_b;
  logic [7:0]  b_rem;
  logic [5:0]  g_rem;
  logic [7:0]  gray;

  assign n     = index - CUBE_BASE;
  assign p6    = 18'(n * 10'd171);
  assign q6    = p6[15:10];
  assign p36   = 14'(q6 * 8'd43);
  assign d_r   = p36[10:8];
  assign g_rem = q6 - 6'(d_r * 3'd6);
  assign d_g   = g_rem[2:0];
  assign b_rem = n - 8'(q6 * 4'd6);
  assign d_b   = b_rem[2:0];

  assign gray = 8'd8 + 8'((index - GRAY_BASE) * 4'd10);

  always_comb begin
    if (index < BASIC_LIMIT) begin
      rgb = basic_rgb(index[3:0]);
    end else if (index < GRAY_BASE) begin
      rgb = {cube_level(d_r), cube_level(d_g), cube_level(d_b)};
    end else begin
      rgb = {gray, gray, gray};
    end
  end

endmodule

// File: hw/rtl/terminal_color_mapper_core.sv
// Terminal color mapper: converts one cell color per clock for a display pipeline.
// Input channel: an item is a transfer at a rising edge with start high and busy low.
// busy is always low, so a new color may be presented in every cycle.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index
// (0: direct RGB output, 1: 256-color display); write only while no item is in flight.
// Result channel: out_valid marks a result for exactly one cycle; the receiver takes
// it in that cycle and cannot stall the block.
// Pipeline: the input transfer loads the input register; the quantizer or palette
// expander then feeds the result register, which drives out_valid and the result.
// Throughput is one color per cycle, set by the single pass through that logic.
// Reset clears both pipeline valid flags and sets direct RGB off and the 256-color
// display on; results in flight at reset are dropped.
module terminal_color_mapper_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_default_flag,
  input  logic                           in_rgb_flag,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_palette_index,
  input  logic                           cfg_we,
  input  logic [tcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                           cfg_wdata,
  output logic                           out_valid,
  output logic                           out_no_color,
  output logic [23:0]                    out_color_value
);
  import tcm_pkg::*;

  cfg_t       cfg_r;
  logic       in_valid_r;
  logic       dflt_r;
  logic       isrgb_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic [7:0] pidx_r;
  logic       out_valid_r;
  logic       no_color_r;
  rgb_t       color_r;
  logic       no_color_nxt;
  rgb_t       color_nxt;
  logic [7:0] quant_idx;
  logic [7:0] sel_idx;
  rgb_t       expand_rgb;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direct_rgb   <= 1'b0;
      cfg_r.wide_palette <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECT_RGB:   cfg_r.direct_rgb   <= cfg_wdata;
        CFG_WIDE_PALETTE: cfg_r.wide_palette <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dflt_r  <= in_default_flag;
      isrgb_r <= in_rgb_flag;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      pidx_r  <= in_palette_index;
    end
  end

  tcm_quantize u_quantize (
    .red   (red_r),
    .green (green_r),
    .blue  (blue_r),
    .index (quant_idx)
  );

  tcm_expand u_expand (
    .index (pidx_r),
    .rgb   (expand_rgb)
  );

  assign sel_idx = isrgb_r ? quant_idx : pidx_r;

  always_comb begin
    no_color_nxt = 1'b0;
    color_nxt    = '0;
    if (dflt_r) begin
      no_color_nxt = 1'b1;
    end else if (cfg_r.direct_rgb) begin
      color_nxt = isrgb_r ? {red_r, green_r, blue_r} : expand_rgb;
    end else if (cfg_r.wide_palette) begin
      color_nxt = {16'd0, sel_idx};
    end else if (sel_idx < BASIC_LIMIT) begin
      color_nxt = {21'd0, sel_idx[2:0]};
    end else begin
      no_color_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      no_color_r <= no_color_nxt;
      color_r    <= color_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_no_color    = no_color_r;
  assign out_color_value = color_r;

endmodule

// File: bench/terminal_color_mapper_core_tb.sv
`timescale 1ns / 100ps

module terminal_color_mapper_core_tb;
  import tcm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int CELLS_PER_PHASE = 305;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic       default_flag;
    logic       rgb_flag;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] palette_index;
  } cell_color_t;

  typedef struct packed {
    logic        no_color;
    logic [23:0] color_value;
  } display_color_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_default_flag = 1'b0;
  logic                 in_rgb_flag = 1'b0;
  logic [7:0]           in_red = 8'd0;
  logic [7:0]           in_green = 8'd0;
  logic [7:0]           in_blue = 8'd0;
  logic [7:0]           in_palette_index = 8'd0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DIRECT_RGB;
  logic                 cfg_wdata = 1'b0;
  logic                 out_valid;
  logic                 out_no_color;
  logic [23:0]          out_color_value;

  cell_color_t    cells_to_send[$];
  display_color_t expected_colors[$];
  logic           in_xfer = 1'b0;
  logic           no_gaps = 1'b0;
  logic           direct_mode = 1'b0;
  logic           wide_mode = 1'b1;
  int             error_count = 0;
  int             cycle_count = 0;
  int             results_checked = 0;
  int             default_cells = 0;
  int             rgb_cells = 0;
  int             palette_cells = 0;
  int             settings_used = 0;

  terminal_color_mapper_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_default_flag (in_default_flag),
    .in_rgb_flag     (in_rgb_flag),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_palette_index(in_palette_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_no_color    (out_no_color),
    .out_color_value (out_color_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [23:0] basic_color(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hCD0000;
      4'd2:    c = 24'h00CD00;
      4'd3:    c = 24'hCDCD00;
      4'd4:    c = 24'h0000EE;
      4'd5:    c = 24'hCD00CD;
      4'd6:    c = 24'h00CDCD;
      4'd7:    c = 24'hE5E5E5;
      4'd8:    c = 24'h7F7F7F;
      4'd9:    c = 24'hFF0000;
      4'd10:   c = 24'h00FF00;
      4'd11:   c = 24'hFFFF00;
      4'd12:   c = 24'h5C5CFF;
      4'd13:   c = 24'hFF00FF;
      4'd14:   c = 24'h00FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cube_intensity(input int unsigned step);
    int unsigned lvl;
    lvl = (step == 0) ? 0 : 55 + 40 * step;
    return lvl[7:0];
  endfunction

  function automatic int unsigned cube_coord(input logic [7:0] v);
    return (v > 8'd47) ? (32'(v) - 35) / 40 : 0;
  endfunction

  function automatic logic [23:0] expand_index(input logic [7:0] idx);
    int unsigned n;
    logic [7:0]  gray;
    if (idx < 8'd16) begin
      return basic_color(idx[3:0]);
    end
    if (idx < 8'd232) begin
      n = 32'(idx) - 16;
      return {cube_intensity(n / 36), cube_intensity((n / 6) % 6), cube_intensity(n % 6)};
    end
    gray = 8'(8 + (32'(idx) - 232) * 10);
    return {gray, gray, gray};
  endfunction

  function automatic logic [7:0] quantize_rgb(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    int unsigned idx;
    if (r == g && g == b) begin
      if (r < 8'd8) begin
        idx = 16;
      end else if (r > 8'd248) begin
        idx = 231;
      end else begin
        idx = 232 + (32'(r) - 8) * 24 / 240;
      end
      if (idx > 255) begin
        idx = 255;
      end
    end else begin
      idx = 16 + 36 * cube_coord(r) + 6 * cube_coord(g) + cube_coord(b);
    end
    return idx[7:0];
  endfunction

  function automatic display_color_t map_cell_color(input cell_color_t c, input logic direct,
                                                    input logic wide);
    display_color_t res;
    logic [7:0]     idx;
    res.no_color = 1'b0;
    res.color_value = 24'd0;
    if (c.default_flag) begin
      res.no_color = 1'b1;
    end else if (direct) begin
      res.color_value = c.rgb_flag ? {c.red, c.green, c.blue} : expand_index(c.palette_index);
    end else begin
      idx = c.rgb_flag ? quantize_rgb(c.red, c.green, c.blue) : c.palette_index;
      if (wide) begin
        res.color_value = {16'd0, idx};
      end else if (idx < 8'd16) begin
        res.color_value = {21'd0, idx[2:0]};
      end else begin
        res.no_color = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic cell_color_t random_cell();
    cell_color_t c;
    logic [7:0]  level;
    c.default_flag = ($urandom_range(99) < 10);
    c.rgb_flag = 1'($urandom_range(1));
    c.red = 8'($urandom_range(255));
    c.green = 8'($urandom_range(255));
    c.blue = 8'($urandom_range(255));
    c.palette_index = ($urandom_range(99) < 30) ? 8'($urandom_range(15))
                                                : 8'($urandom_range(255));
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0:       level = 8'd248;
        1:       level = 8'($urandom_range(9));
        2:       level = 8'($urandom_range(255, 245));
        default: level = 8'($urandom_range(255));
      endcase
      c.red = level;
      c.green = level;
      c.blue = level;
    end
    return c;
  endfunction

  task automatic push_cell(input logic d, input logic rg, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic [7:0] p);
    cells_to_send.push_back({d, rg, r, g, b, p});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (!(cells_to_send.size() == 0 && !start && expected_colors.size() == 0)) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_setting(input logic direct, input logic wide);
    wait_drained();
    write_reg(CFG_DIRECT_RGB, direct);
    write_reg(CFG_WIDE_PALETTE, wide);
    settings_used++;
  endtask

  always @(negedge clk) begin : drive_proc
    cell_color_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !in_xfer)) begin
      if (cells_to_send.size() == 0 || (!no_gaps && $urandom_range(99) < 38)) begin
        nxt = random_cell();
        start <= 1'b0;
      end else begin
        nxt = cells_to_send.pop_front();
        start <= 1'b1;
      end
      in_default_flag <= nxt.default_flag;
      in_rgb_flag <= nxt.rgb_flag;
      in_red <= nxt.red;
      in_green <= nxt.green;
      in_blue <= nxt.blue;
      in_palette_index <= nxt.palette_index;
    end
  end

  always @(posedge clk) begin : monitor_proc
    cell_color_t    sent_color;
    display_color_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               expected_colors.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst_n) begin
      in_xfer <= 1'b0;
      direct_mode = 1'b0;
      wide_mode = 1'b1;
    end else begin
      in_xfer <= start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECT_RGB:   direct_mode = cfg_wdata;
          CFG_WIDE_PALETTE: wide_mode = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        sent_color = {in_default_flag, in_rgb_flag, in_red, in_green, in_blue,
                      in_palette_index};
        expected_colors.push_back(map_cell_color(sent_color, direct_mode, wide_mode));
        if (sent_color.default_flag) begin
          default_cells++;
        end else if (sent_color.rgb_flag) begin
          rgb_cells++;
        end else begin
          palette_cells++;
        end
      end
      if (out_valid) begin
        if (expected_colors.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("Unexpected result: no_color=%0b color_value=%06h", out_no_color,
                     out_color_value);
          end
        end else begin
          want = expected_colors.pop_front();
          results_checked++;
          if (out_no_color !== want.no_color || out_color_value !== want.color_value) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("Mismatch at result %0d: expected %0b/%06h, got %0b/%06h",
                       results_checked, want.no_color, want.color_value, out_no_color,
                       out_color_value);
            end
          end
        end
      end
    end
  end

  initial begin : stimulus_proc
    logic [1:0] setting;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    push_cell(1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
    push_cell(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd255);
    push_cell(1'b0, 1'b1, 8'd7, 8'd7, 8'd7, 8'd0);
    push_cell(1'b0, 1'b1, 8'd8, 8'd8, 8'd8, 8'd0);
    push_cell(1'b0, 1'b1, 8'd247, 8'd247, 8'd247, 8'd0);
    push_cell(1'b0, 1'b1, 8'd248, 8'd248, 8'd248, 8'd0);
    push_cell(1'b0, 1'b1, 8'd249, 8'd249, 8'd249, 8'd0);
    push_cell(1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 8'd0);
    push_cell(1'b0, 1'b1, 8'd255, 8'd0, 8'd128, 8'd0);
    push_cell(1'b0, 1'b1, 8'd47, 8'd48, 8'd75, 8'd0);
    push_cell(1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255);

    apply_setting(1'b0, 1'b0);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd15);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd16);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd7);
    push_cell(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
    push_cell(1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd3);

    apply_setting(1'b1, 1'b0);
    push_cell(1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd15);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd16);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd231);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd232);
    push_cell(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255);
    push_cell(1'b0, 1'b1, 8'd255, 8'd128, 8'd1, 8'd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       setting = 2'b01;
        1:       setting = 2'b00;
        2:       setting = 2'b11;
        3:       setting = 2'b10;
        default: setting = 2'($urandom_range(3));
      endcase
      apply_setting(setting[1], setting[0]);
      no_gaps = (ph == 2);
      for (int i = 0; i < CELLS_PER_PHASE; i++) begin
        cells_to_send.push_back(random_cell());
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    error_count += expected_colors.size();
    $display("Checked %0d results from %0d default, %0d RGB and %0d palette cells.",
             results_checked, default_cells, rgb_cells, palette_cells);
    $display("The run went through %0d register settings, covering all four mode pairs.",
             settings_used);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tcm_pkg.sv
hw/rtl/tcm_quantize.sv
hw/rtl/tcm_expand.sv
hw/rtl/terminal_color_mapper_core.sv
bench/terminal_color_mapper_core_tb.sv
